>>> hdl/vrsf_pkg.sv
package vrsf_pkg;

  // func codes of an input item
  localparam logic [2:0] FN_TICK   = 3'd0;
  localparam logic [2:0] FN_SET    = 3'd1;
  localparam logic [2:0] FN_STOP   = 3'd2;
  localparam logic [2:0] FN_RESUME = 3'd3;
  localparam logic [2:0] FN_CLEAR  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_ACCEL     = 3'd0;
  localparam logic [2:0] CFG_DECEL     = 3'd1;
  localparam logic [2:0] CFG_VEL_ALPHA = 3'd2;
  localparam logic [2:0] CFG_OUT_ALPHA = 3'd3;
  localparam logic [2:0] CFG_RAMP_EN   = 3'd4;
  localparam logic [2:0] CFG_FILT_EN   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STEP,
    ST_RAMP,
    ST_LP1_MUL,
    ST_LP1_ADD,
    ST_LP2_MUL,
    ST_LP2_ADD,
    ST_BYPASS,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_STEP,
    MUL_LP1,
    MUL_LP2
  } mul_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     exec;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     ramp_upd;
    logic     lp1_upd;
    logic     lp2_upd;
    logic     bypass;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic tick_go;
    logic ramp_en;
    logic filter_en;
  } dp_status_t;

endpackage

>>> hdl/vrsf_ctrl.sv
module vrsf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  vrsf_pkg::dp_status_t status_i,
  output vrsf_pkg::dp_cmd_t    cmd_o
);

  vrsf_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != vrsf_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vrsf_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = vrsf_pkg::ST_EXEC;
      end
      vrsf_pkg::ST_EXEC: begin
        if (!status_i.tick_go)      state_d = vrsf_pkg::ST_DONE;
        else if (status_i.ramp_en)  state_d = vrsf_pkg::ST_STEP;
        else if (status_i.filter_en) state_d = vrsf_pkg::ST_LP1_MUL;
        else                        state_d = vrsf_pkg::ST_BYPASS;
      end
      vrsf_pkg::ST_STEP: state_d = vrsf_pkg::ST_RAMP;
      vrsf_pkg::ST_RAMP: begin
        state_d = status_i.filter_en ? vrsf_pkg::ST_LP1_MUL : vrsf_pkg::ST_BYPASS;
      end
      vrsf_pkg::ST_LP1_MUL: state_d = vrsf_pkg::ST_LP1_ADD;
      vrsf_pkg::ST_LP1_ADD: state_d = vrsf_pkg::ST_LP2_MUL;
      vrsf_pkg::ST_LP2_MUL: state_d = vrsf_pkg::ST_LP2_ADD;
      vrsf_pkg::ST_LP2_ADD: state_d = vrsf_pkg::ST_DONE;
      vrsf_pkg::ST_BYPASS:  state_d = vrsf_pkg::ST_DONE;
      vrsf_pkg::ST_DONE: begin
        if (out_free) state_d = vrsf_pkg::ST_IDLE;
      end
      default: state_d = vrsf_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o       = '0;
    cmd_o.mul_sel = vrsf_pkg::MUL_STEP;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      vrsf_pkg::ST_IDLE:    cmd_o.load_in = in_valid_i;
      vrsf_pkg::ST_EXEC:    cmd_o.exec = 1'b1;
      vrsf_pkg::ST_STEP:    cmd_o.mul_en = 1'b1;
      vrsf_pkg::ST_RAMP:    cmd_o.ramp_upd = 1'b1;
      vrsf_pkg::ST_LP1_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = vrsf_pkg::MUL_LP1;
      end
      vrsf_pkg::ST_LP1_ADD: cmd_o.lp1_upd = 1'b1;
      vrsf_pkg::ST_LP2_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = vrsf_pkg::MUL_LP2;
      end
      vrsf_pkg::ST_LP2_ADD: cmd_o.lp2_upd = 1'b1;
      vrsf_pkg::ST_BYPASS:  cmd_o.bypass = 1'b1;
      vrsf_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vrsf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hdl/vrsf_dp.sv
module vrsf_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vrsf_pkg::dp_cmd_t    cmd_i,
  output vrsf_pkg::dp_status_t status_o,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_index_i,
  input  logic [8:0]           cfg_data_i,
  input  logic [2:0]           func_i,
  input  logic [16:0]          tick_period_i,
  input  logic signed [15:0]   target_speed_i,
  output logic signed [15:0]   drive_output_o,
  output logic                 period_rejected_o,
  output logic                 stop_active_o
);

  localparam logic signed [15:0] SpeedMax = 16'sd25600;
  localparam logic signed [20:0] SpeedMaxW = 21'sd25600;
  localparam logic [16:0]        Deadband = 17'd26;
  localparam logic [16:0]        PeriodMax = 17'd65536;
  localparam logic [8:0]         StopDecel = 9'd200;

  // configuration
  logic [7:0] accel_q;
  logic [8:0] decel_q, va_q, oa_q;
  logic       ren_q, fen_q;

  // architectural state
  logic signed [15:0] goal_q, ramp_q, smooth_q, held_q;
  logic               stop_q, ovr_q, rej_q;

  // item and working registers
  logic [2:0]         func_q;
  logic [16:0]        dt_q;
  logic signed [15:0] tgt_q;
  logic signed [16:0] diff_q;
  logic signed [27:0] prod_q;

  // result registers
  logic signed [15:0] drive_q;
  logic               rej_out_q, stop_out_q;

  logic               dt_ok;
  logic [7:0]         accel_c;
  logic [8:0]         decel_c, va_c, oa_c, rate;
  logic signed [16:0] goal_eff, diff_d, d_lp1, d_lp2;
  logic signed [17:0] mul_a;
  logic signed [9:0]  mul_b;
  logic signed [27:0] prod_d;
  logic [16:0]        mag;
  logic [19:0]        step;
  logic               snap;
  logic signed [16:0] ramp_w, step_w, ramp_mv;
  logic signed [28:0] lp_sum1, lp_sum2;
  logic signed [20:0] lp_y2;
  logic signed [15:0] held_sat, tgt_sat;

  assign dt_ok = (dt_q != 17'd0) && (dt_q <= PeriodMax);
  assign status_o.tick_go   = (func_q == vrsf_pkg::FN_TICK) && dt_ok;
  assign status_o.ramp_en   = ren_q;
  assign status_o.filter_en = fen_q;

  // register values are clamped where used
  always_comb begin
    accel_c = (accel_q == 8'd0) ? 8'd1 : ((accel_q > 8'd200) ? 8'd200 : accel_q);
    decel_c = (decel_q == 9'd0) ? 9'd1 : ((decel_q > 9'd500) ? 9'd500 : decel_q);
    va_c    = (va_q < 9'd26) ? 9'd26 : ((va_q > 9'd256) ? 9'd256 : va_q);
    oa_c    = (oa_q < 9'd26) ? 9'd26 : ((oa_q > 9'd256) ? 9'd256 : oa_q);
    rate    = !diff_q[16] ? {1'b0, accel_c} : (ovr_q ? StopDecel : decel_c);
  end

  assign tgt_sat = (tgt_q > SpeedMax) ? SpeedMax :
                   ((tgt_q < -SpeedMax) ? -SpeedMax : tgt_q);

  assign goal_eff = stop_q ? 17'sd0 : {goal_q[15], goal_q};
  assign diff_d   = goal_eff - {ramp_q[15], ramp_q};

  // shared multiplier
  assign d_lp1 = {ramp_q[15], ramp_q} - {smooth_q[15], smooth_q};
  assign d_lp2 = {smooth_q[15], smooth_q} - {held_q[15], held_q};

  always_comb begin
    case (cmd_i.mul_sel)
      vrsf_pkg::MUL_STEP: begin
        mul_a = {1'b0, dt_q};
        mul_b = {1'b0, rate};
      end
      vrsf_pkg::MUL_LP1: begin
        mul_a = {d_lp1[16], d_lp1};
        mul_b = {1'b0, va_c};
      end
      vrsf_pkg::MUL_LP2: begin
        mul_a = {d_lp2[16], d_lp2};
        mul_b = {1'b0, oa_c};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // ramp step: product is never negative here
  assign mag     = diff_q[16] ? -diff_q : diff_q;
  assign step    = prod_q[27:8];
  assign snap    = (mag < Deadband) || ({3'b000, mag} <= step);
  assign ramp_w  = {ramp_q[15], ramp_q};
  assign step_w  = {1'b0, step[15:0]};
  assign ramp_mv = diff_q[16] ? (ramp_w - step_w) : (ramp_w + step_w);

  // y = floor((256*y_prev + a*(x - y_prev) + 128) / 256)
  assign lp_sum1 = $signed({{5{smooth_q[15]}}, smooth_q, 8'd0}) + {prod_q[27], prod_q}
                   + 29'sd128;
  assign lp_sum2 = $signed({{5{held_q[15]}}, held_q, 8'd0}) + {prod_q[27], prod_q}
                   + 29'sd128;
  assign lp_y2   = lp_sum2[28:8];
  assign held_sat = (lp_y2 > SpeedMaxW) ? SpeedMax :
                    ((lp_y2 < -SpeedMaxW) ? -SpeedMax : lp_y2[15:0]);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= func_i;
      dt_q   <= tick_period_i;
      tgt_q  <= target_speed_i;
    end
    if (cmd_i.exec) diff_q <= diff_d;
    if (cmd_i.mul_en) prod_q <= prod_d;
    if (cmd_i.out_load) begin
      drive_q    <= held_q;
      rej_out_q  <= rej_q;
      stop_out_q <= stop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q  <= 8'd50;
      decel_q  <= 9'd100;
      va_q     <= 9'd77;
      oa_q     <= 9'd128;
      ren_q    <= 1'b1;
      fen_q    <= 1'b1;
      goal_q   <= '0;
      ramp_q   <= '0;
      smooth_q <= '0;
      held_q   <= '0;
      stop_q   <= 1'b0;
      ovr_q    <= 1'b0;
      rej_q    <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        rej_q <= 1'b0;
        case (func_q)
          vrsf_pkg::FN_TICK: begin
            if (!dt_ok) begin
              rej_q <= 1'b1;
            end else begin
              if (stop_q) begin
                goal_q <= '0;
                ovr_q  <= 1'b1;
              end
              if (!ren_q) ramp_q <= goal_eff[15:0];
            end
          end
          vrsf_pkg::FN_SET: goal_q <= tgt_sat;
          vrsf_pkg::FN_STOP: begin
            stop_q <= 1'b1;
            goal_q <= '0;
          end
          vrsf_pkg::FN_RESUME: stop_q <= 1'b0;
          vrsf_pkg::FN_CLEAR: begin
            goal_q   <= '0;
            ramp_q   <= '0;
            smooth_q <= '0;
            held_q   <= '0;
            stop_q   <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.ramp_upd) ramp_q <= snap ? goal_q : ramp_mv[15:0];
      if (cmd_i.lp1_upd) smooth_q <= lp_sum1[23:8];
      if (cmd_i.lp2_upd) held_q <= held_sat;
      if (cmd_i.bypass) begin
        smooth_q <= ramp_q;
        held_q   <= ramp_q;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          vrsf_pkg::CFG_ACCEL:     accel_q <= cfg_data_i[7:0];
          vrsf_pkg::CFG_DECEL: begin
            decel_q <= cfg_data_i;
            ovr_q   <= 1'b0;
          end
          vrsf_pkg::CFG_VEL_ALPHA: va_q  <= cfg_data_i;
          vrsf_pkg::CFG_OUT_ALPHA: oa_q  <= cfg_data_i;
          vrsf_pkg::CFG_RAMP_EN:   ren_q <= cfg_data_i[0];
          vrsf_pkg::CFG_FILT_EN:   fen_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  assign drive_output_o    = drive_q;
  assign period_rejected_o = rej_out_q;
  assign stop_active_o     = stop_out_q;

endmodule

>>> hdl/velocity_ramp_and_smoothing_filter.sv
// Channel  | Handshake                | Payload
// ---------+--------------------------+------------------------------------------
// input    | in_valid_i / in_stall_o  | func_i, tick_period_i, target_speed_i
// result   | out_valid_o / out_stall_i| drive_output_o, period_rejected_o,
//          |                          | stop_active_o
// config   | cfg_we_i (no wait)       | cfg_index_i, cfg_data_i
//
// An item is taken in the idle state and worked on alone. Set target, stop,
// resume, clear state, spare codes and a rejected tick go from execute
// straight to done; a valid tick first takes the ramp step and update, unless
// the ramp is off, then the two low-pass stages, or a bypass step with the
// filters off. A single shared multiplier serves in turn the ramp step and
// each of the two low-pass stages, each product registered before its add.
// Reset clears the control, the motion state and loads the register defaults.
// The result register holds a finished item while out_stall_i is high; the
// next item is accepted meanwhile and waits in its last state if needed.
module velocity_ramp_and_smoothing_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic [16:0]        tick_period_i,
  input  logic signed [15:0] target_speed_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] drive_output_o,
  output logic               period_rejected_o,
  output logic               stop_active_o
);

  vrsf_pkg::dp_cmd_t    cmd;
  vrsf_pkg::dp_status_t status;

  // sequencer: steps the datapath through one item
  vrsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // ramp, two low-pass stages, settings and the result register
  vrsf_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .func_i            (func_i),
    .tick_period_i     (tick_period_i),
    .target_speed_i    (target_speed_i),
    .drive_output_o    (drive_output_o),
    .period_rejected_o (period_rejected_o),
    .stop_active_o     (stop_active_o)
  );

endmodule

>>> verif/velocity_ramp_and_smoothing_filter_tb.sv
module velocity_ramp_and_smoothing_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // func codes the block leaves alone: the held output comes straight back
  localparam logic [2:0] FN_SPARE_LO  = 3'd5;
  localparam logic [2:0] FN_SPARE_MID = 3'd6;
  localparam logic [2:0] FN_SPARE_HI  = 3'd7;

  localparam int SPEED_TOP  = 25600;
  localparam int DEADBAND   = 26;
  localparam int PERIOD_TOP = 65536;
  localparam int STOP_RATE  = 200;

  localparam int DIR_ROWS        = 25;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int IDLE_PCT        = 22;
  localparam int SETTLE_CYCLES   = 12;
  localparam int STALL_LIMIT     = 4000; // cycles without any handshake
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic signed [15:0] drive;
    logic               rejected;
    logic               stop;
  } drive_res_t;

  typedef struct packed {
    logic [2:0]         fn;
    logic [16:0]        dt;
    logic signed [15:0] tgt;
    logic               typed;   // res holds the expected item when set
    drive_res_t         res;
  } stim_row_t;

  localparam drive_res_t HELD_ZERO   = '{16'sd0, 1'b0, 1'b0};
  localparam drive_res_t REJECT_ZERO = '{16'sd0, 1'b1, 1'b0};

  logic               clk_i;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [2:0]         cfg_index_i    = vrsf_pkg::CFG_ACCEL;
  logic [8:0]         cfg_data_i     = '0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [2:0]         func_i         = vrsf_pkg::FN_TICK;
  logic [16:0]        tick_period_i  = '0;
  logic signed [15:0] target_speed_i = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic signed [15:0] drive_output_o;
  logic               period_rejected_o;
  logic               stop_active_o;

  velocity_ramp_and_smoothing_filter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .func_i           (func_i),
    .tick_period_i    (tick_period_i),
    .target_speed_i   (target_speed_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .drive_output_o   (drive_output_o),
    .period_rejected_o(period_rejected_o),
    .stop_active_o    (stop_active_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Drive model: own copy of the registers (raw, as written) and of the motion
  // state. Register values are clamped only where they are used, as the block
  // does it.
  // ---------------------------------------------------------------------------
  logic [7:0] accel_reg  = 8'd50;
  logic [8:0] decel_reg  = 9'd100;
  logic [8:0] valpha_reg = 9'd77;
  logic [8:0] oalpha_reg = 9'd128;
  logic       ramp_on    = 1'b1;
  logic       filt_on    = 1'b1;

  int   goal_spd     = 0;
  int   ramp_spd     = 0;
  int   smooth_spd   = 0;
  int   held_spd     = 0;
  logic stop_latched = 1'b0;
  logic decel_ovr    = 1'b0;

  drive_res_t drive_q[$];   // expected result items, oldest first

  int  errors     = 0;
  bit  quiet      = 1'b0;   // no idling on either side while set
  int  n_items    = 0;
  int  n_ticks    = 0;
  int  n_rejected = 0;
  int  n_stops    = 0;
  int  n_clears   = 0;
  int  n_writes   = 0;
  int  idle_cycles = 0;

  function automatic int clip(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // first-order low-pass, round to nearest with ties upward (floor of sum+128)
  function automatic int iir_stage(input int x, input int prev, input logic [8:0] alpha);
    int a;
    int acc;
    a   = clip(int'(alpha), 26, 256);
    acc = a * x + (256 - a) * prev;
    return (acc + 128) >>> 8;
  endfunction

  task automatic advance_drive_model(input logic [2:0] fn, input logic [16:0] dt,
                                     input logic signed [15:0] tgt,
                                     output drive_res_t res);
    int   diff;
    int   mag;
    int   rate;
    int   step_sz;
    logic rej;
    rej = 1'b0;
    case (fn)
      vrsf_pkg::FN_TICK: begin
        if (dt == 0 || int'(dt) > PERIOD_TOP) begin
          rej = 1'b1;
        end else begin
          // a stop in force pins the goal at zero and latches the fast decel
          if (stop_latched) begin
            goal_spd  = 0;
            decel_ovr = 1'b1;
          end
          if (ramp_on) begin
            diff = goal_spd - ramp_spd;
            mag  = (diff < 0) ? -diff : diff;
            if (mag < DEADBAND) begin
              ramp_spd = goal_spd;
            end else begin
              if (diff > 0) rate = clip(int'(accel_reg), 1, 200);
              else if (decel_ovr) rate = STOP_RATE;
              else rate = clip(int'(decel_reg), 1, 500);
              step_sz = (rate * int'(dt)) >>> 8;
              if (mag <= step_sz) ramp_spd = goal_spd;
              else ramp_spd = ramp_spd + ((diff > 0) ? step_sz : -step_sz);
            end
          end else begin
            ramp_spd = goal_spd;
          end
          if (filt_on) begin
            smooth_spd = iir_stage(ramp_spd, smooth_spd, valpha_reg);
            held_spd   = iir_stage(smooth_spd, held_spd, oalpha_reg);
          end else begin
            smooth_spd = ramp_spd;
            held_spd   = smooth_spd;
          end
          held_spd = clip(held_spd, -SPEED_TOP, SPEED_TOP);
        end
      end
      vrsf_pkg::FN_SET: goal_spd = clip(int'(tgt), -SPEED_TOP, SPEED_TOP);
      vrsf_pkg::FN_STOP: begin
        stop_latched = 1'b1;
        goal_spd     = 0;
      end
      vrsf_pkg::FN_RESUME: stop_latched = 1'b0;
      vrsf_pkg::FN_CLEAR: begin
        // motion state only: registers and the decel latch survive
        goal_spd     = 0;
        ramp_spd     = 0;
        smooth_spd   = 0;
        held_spd     = 0;
        stop_latched = 1'b0;
      end
      default: ;
    endcase
    res.drive    = 16'(held_spd);
    res.rejected = rej;
    res.stop     = stop_latched;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table: extremes of every field, each func code, invalid periods,
  // stop with a set target pending, resume, clear state and the deadband snap.
  // Only the rows whose result is obvious carry a typed expectation.
  // ---------------------------------------------------------------------------
  stim_row_t dir_tab [DIR_ROWS] = '{
    '{vrsf_pkg::FN_TICK,   17'd0,     16'sd0,     1'b1, REJECT_ZERO}, // zero period
    '{vrsf_pkg::FN_TICK,   17'd65537, -16'sd1,    1'b1, REJECT_ZERO}, // just too long
    '{vrsf_pkg::FN_TICK,   17'h1FFFF, 16'sh7FFF,  1'b1, REJECT_ZERO}, // all period bits
    '{FN_SPARE_LO,         17'h1FFFF, 16'sh8000,  1'b1, HELD_ZERO},
    '{FN_SPARE_HI,         17'd0,     16'sd0,     1'b1, HELD_ZERO},
    '{vrsf_pkg::FN_SET,    17'd0,     16'sh7FFF,  1'b1, HELD_ZERO},   // saturates to top
    '{vrsf_pkg::FN_TICK,   17'd65536, 16'sd0,     1'b0, HELD_ZERO},   // longest period
    '{vrsf_pkg::FN_TICK,   17'd65536, 16'sd0,     1'b0, HELD_ZERO},
    '{vrsf_pkg::FN_TICK,   17'd1,     16'sd0,     1'b0, HELD_ZERO},   // step rounds to 0
    '{vrsf_pkg::FN_SET,    17'h1FFFF, 16'sh8000,  1'b0, HELD_ZERO},   // saturates to bottom
    '{vrsf_pkg::FN_TICK,   17'd65536, 16'sd0,     1'b0, HELD_ZERO},
    '{vrsf_pkg::FN_TICK,   17'd256,   16'sd0,     1'b0, HELD_ZERO},
    '{vrsf_pkg::FN_STOP,   17'd100,   16'sd5000,  1'b0, HELD_ZERO},
    '{vrsf_pkg::FN_SET,    17'd0,     16'sd20000, 1'b0, HELD_ZERO},   // stored, not used
    '{vrsf_pkg::FN_TICK,   17'd65536, 16'sd0,     1'b0, HELD_ZERO},   // forced to zero
    '{vrsf_pkg::FN_RESUME, 17'd0,     16'sd0,     1'b0, HELD_ZERO},
    '{vrsf_pkg::FN_SET,    17'd0,     16'sd25600, 1'b0, HELD_ZERO},
    '{vrsf_pkg::FN_TICK,   17'd4096,  16'sd0,     1'b0, HELD_ZERO},
    '{FN_SPARE_MID,        17'd4096,  16'sd1,     1'b0, HELD_ZERO},
    '{vrsf_pkg::FN_CLEAR,  17'd9,     -16'sd9,    1'b1, HELD_ZERO},
    '{vrsf_pkg::FN_SET,    17'd0,     16'sd20,    1'b0, HELD_ZERO},   // inside deadband
    '{vrsf_pkg::FN_TICK,   17'd1,     16'sd0,     1'b0, HELD_ZERO},
    '{vrsf_pkg::FN_SET,    17'd0,     -16'sd25,   1'b0, HELD_ZERO},   // outside it as seen from the ramp
    '{vrsf_pkg::FN_TICK,   17'd1,     16'sd0,     1'b0, HELD_ZERO},
    '{vrsf_pkg::FN_TICK,   17'd65536, 16'sd0,     1'b0, HELD_ZERO}
  };

  // ---------------------------------------------------------------------------
  // Sender side. Every task here is entered and left at a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [2:0] fn, input logic [16:0] dt,
                           input logic signed [15:0] tgt,
                           input logic typed, input drive_res_t typed_res);
    drive_res_t res;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    func_i         = fn;
    tick_period_i  = dt;
    target_speed_i = tgt;
    do @(posedge clk_i); while (in_stall_o);
    // accepted at this edge: the model always runs, a typed row overrides it
    advance_drive_model(fn, dt, tgt, res);
    drive_q.push_back(typed ? typed_res : res);
    n_items++;
    if (fn == vrsf_pkg::FN_TICK) n_ticks++;
    if (res.rejected) n_rejected++;
    if (fn == vrsf_pkg::FN_STOP) n_stops++;
    if (fn == vrsf_pkg::FN_CLEAR) n_clears++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one register write per call; the model takes it at once, the block is idle
  task automatic write_cfg(input logic [2:0] idx, input logic [8:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    case (idx)
      vrsf_pkg::CFG_ACCEL: accel_reg = val[7:0];
      vrsf_pkg::CFG_DECEL: begin
        decel_reg = val;
        decel_ovr = 1'b0;   // a decel write releases the stop override
      end
      vrsf_pkg::CFG_VEL_ALPHA: valpha_reg = val;
      vrsf_pkg::CFG_OUT_ALPHA: oalpha_reg = val;
      vrsf_pkg::CFG_RAMP_EN:   ramp_on    = val[0];
      vrsf_pkg::CFG_FILT_EN:   filt_on    = val[0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // mostly in the useful band, now and then beyond either clamp
  function automatic logic [8:0] rand_alpha();
    return ($urandom_range(9) < 8) ? 9'($urandom_range(256, 26)) : 9'($urandom_range(511));
  endfunction

  task automatic load_setting(input int ph);
    case (ph)
      0: begin   // low extremes, clamped up where used
        write_cfg(vrsf_pkg::CFG_ACCEL,     9'd0);
        write_cfg(vrsf_pkg::CFG_DECEL,     9'd0);
        write_cfg(vrsf_pkg::CFG_VEL_ALPHA, 9'd0);
        write_cfg(vrsf_pkg::CFG_OUT_ALPHA, 9'd26);
        write_cfg(vrsf_pkg::CFG_RAMP_EN,   9'd1);
        write_cfg(vrsf_pkg::CFG_FILT_EN,   9'd1);
      end
      1: begin   // high extremes, all data bits set except in the output alpha
        write_cfg(vrsf_pkg::CFG_ACCEL,     9'h1FF);
        write_cfg(vrsf_pkg::CFG_DECEL,     9'h1FF);
        write_cfg(vrsf_pkg::CFG_VEL_ALPHA, 9'h1FF);
        write_cfg(vrsf_pkg::CFG_OUT_ALPHA, 9'd256);
        write_cfg(vrsf_pkg::CFG_RAMP_EN,   9'h1FF);
        write_cfg(vrsf_pkg::CFG_FILT_EN,   9'h1FF);
      end
      2: begin   // ramp off, only bit 0 of the enable counts
        write_cfg(vrsf_pkg::CFG_ACCEL,     9'($urandom_range(511)));
        write_cfg(vrsf_pkg::CFG_DECEL,     9'($urandom_range(511)));
        write_cfg(vrsf_pkg::CFG_VEL_ALPHA, rand_alpha());
        write_cfg(vrsf_pkg::CFG_OUT_ALPHA, rand_alpha());
        write_cfg(vrsf_pkg::CFG_RAMP_EN,   9'h1FE);
      end
      3: begin   // top in-range rates, filters bypassed
        write_cfg(vrsf_pkg::CFG_ACCEL,   9'd200);
        write_cfg(vrsf_pkg::CFG_DECEL,   9'd500);
        write_cfg(vrsf_pkg::CFG_RAMP_EN, 9'd1);
        write_cfg(vrsf_pkg::CFG_FILT_EN, 9'h0);
      end
      4: begin   // straight copy of the goal
        write_cfg(vrsf_pkg::CFG_RAMP_EN, 9'd0);
        write_cfg(vrsf_pkg::CFG_FILT_EN, 9'd0);
        write_cfg(vrsf_pkg::CFG_ACCEL,   9'($urandom_range(200, 1)));
      end
      default: begin
        // random subset; leaving decel alone keeps a latched override alive
        if ($urandom_range(1)) write_cfg(vrsf_pkg::CFG_ACCEL, 9'($urandom_range(511)));
        if ($urandom_range(1)) write_cfg(vrsf_pkg::CFG_DECEL, 9'($urandom_range(511)));
        if ($urandom_range(1)) write_cfg(vrsf_pkg::CFG_VEL_ALPHA, rand_alpha());
        if ($urandom_range(1)) write_cfg(vrsf_pkg::CFG_OUT_ALPHA, rand_alpha());
        write_cfg(vrsf_pkg::CFG_RAMP_EN, ($urandom_range(3) != 0) ? 9'd1 : 9'd0);
        write_cfg(vrsf_pkg::CFG_FILT_EN, ($urandom_range(3) != 0) ? 9'd1 : 9'd0);
      end
    endcase
  endtask

  // Random item mix: mostly valid ticks and new targets so the ramp and the
  // filters get a long way, with stops, resumes, clears, bad periods and
  // spare codes as noise. Fields a func ignores still carry random bits.
  task automatic pick_item(output logic [2:0] fn, output logic [16:0] dt,
                           output logic signed [15:0] tgt);
    int sel;
    int spread;
    sel    = $urandom_range(99);
    spread = $urandom_range(99);
    fn     = vrsf_pkg::FN_TICK;
    dt     = 17'($urandom());
    tgt    = 16'($urandom());
    if (sel < 50) begin
      if (spread < 40)      dt = 17'($urandom_range(2048, 1));
      else if (spread < 70) dt = 17'($urandom_range(16384, 2049));
      else if (spread < 90) dt = 17'($urandom_range(65536, 16385));
      else                  dt = $urandom_range(1) ? 17'd65536 : 17'd1;
    end else if (sel < 62) begin
      fn = vrsf_pkg::FN_SET;
      if (spread < 60)      tgt = 16'(int'($urandom_range(51200)) - SPEED_TOP);
      else if (spread < 85) tgt = 16'($urandom());
      else                  tgt = 16'(goal_spd + int'($urandom_range(80)) - 40);
    end else if (sel < 66) begin
      fn = vrsf_pkg::FN_STOP;
    end else if (sel < 71) begin
      fn = vrsf_pkg::FN_RESUME;
    end else if (sel < 74) begin
      fn = vrsf_pkg::FN_CLEAR;
    end else if (sel < 82) begin
      dt = ($urandom_range(3) == 0) ? 17'd0 : 17'($urandom_range(131071, 65537));
    end else if (sel < 86) begin
      fn = 3'($urandom_range(FN_SPARE_HI, FN_SPARE_LO));
    end else begin
      dt = 17'($urandom_range(512, 1));   // short ticks: slow approach, deadband
    end
  endtask

  // receiver stalls at random, except in the quiet phase
  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    drive_res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result item: drive %0d rejected %0b stop %0b",
                   drive_output_o, period_rejected_o, stop_active_o);
      end else begin
        exp_res = drive_q.pop_front();
        if (drive_output_o !== exp_res.drive || period_rejected_o !== exp_res.rejected ||
            stop_active_o !== exp_res.stop) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch at %0t (exp/got): drive %0d/%0d, rej %0b/%0b, stop %0b/%0b",
                     $realtime, exp_res.drive, drive_output_o, exp_res.rejected,
                     period_rejected_o, exp_res.stop, stop_active_o);
        end
      end
    end
  end

  // watchdog: too long without a handshake on either channel means a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: %0d cycles without a handshake, %0d results outstanding",
                 idle_cycles, drive_q.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [2:0]         fn;
    logic [16:0]        dt;
    logic signed [15:0] tgt;
    int                 done_items;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part runs on the reset defaults
    for (int r = 0; r < DIR_ROWS; r++)
      send_item(dir_tab[r].fn, dir_tab[r].dt, dir_tab[r].tgt, dir_tab[r].typed,
                dir_tab[r].res);

    for (int ph = 0; ph < PHASES; ph++) begin
      // registers change only with the block idle and nothing outstanding
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      @(negedge clk_i);
      load_setting(ph);
      quiet      = (ph == 3);
      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        // halfway through one phase the sender holds off until all is back
        if (ph == 5 && done_items == ITEMS_PER_PHASE / 2) drain_results();
        pick_item(fn, dt, tgt);
        send_item(fn, dt, tgt, 1'b0, HELD_ZERO);
        if (fn <= vrsf_pkg::FN_CLEAR) done_items++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d items: %0d ticks (%0d rejected), %0d stops, %0d clears",
             n_items, n_ticks, n_rejected, n_stops, n_clears);
    $display("over %0d register settings with %0d writes, %0d errors",
             PHASES + 1, n_writes, errors);
    if (errors == 0 && drive_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> velocity_ramp_and_smoothing_filter.f
hdl/vrsf_pkg.sv
hdl/vrsf_ctrl.sv
hdl/vrsf_dp.sv
hdl/velocity_ramp_and_smoothing_filter.sv
verif/velocity_ramp_and_smoothing_filter_tb.sv
